FILE: design/ypdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypdt_pkg
// Field widths, payload types, register indexes and the window control group
// shared by the yaw PID differential thrust block.
// ----------------------------------------------------------------------------
package ypdt_pkg;

   localparam int YAW_W     = 16;
   localparam int MS_W      = 10;
   localparam int GAIN_W    = 16;
   localparam int THR_CFG_W = 14;
   localparam int THR_W     = 16;
   localparam int ERR_W     = 15;
   localparam int CSR_IDX_W = 3;

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DERIV_GAIN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_THRUST = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_THRUST  = 3'd4;

   typedef logic signed [YAW_W-1:0]     yaw_type;
   typedef logic        [MS_W-1:0]      ms_type;
   typedef logic        [GAIN_W-1:0]    gain_type;
   typedef logic        [THR_CFG_W-1:0] thrust_cfg_type;
   typedef logic signed [THR_W-1:0]     thrust_type;
   typedef logic        [ERR_W-1:0]     err_type;

   // advance: step the slot and fetch the oldest entry
   // commit:  overwrite that entry with the new error and update the sum
   typedef struct packed {
      logic advance;
      logic commit;
   } win_ctrl_type;

endpackage

FILE: design/ypdt_channels.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypdt channels
// Valid/ready channels for heading samples and thruster commands.
// ----------------------------------------------------------------------------
interface ypdt_req_if;
   logic              valid;
   logic              ready;
   ypdt_pkg::yaw_type measured_yaw;
   ypdt_pkg::yaw_type target_yaw;
   ypdt_pkg::ms_type  elapsed_ms;

   modport source (output valid, output measured_yaw, output target_yaw,
                   output elapsed_ms, input ready);
   modport sink   (input valid, input measured_yaw, input target_yaw,
                   input elapsed_ms, output ready);
endinterface

interface ypdt_rsp_if;
   logic                 valid;
   logic                 ready;
   ypdt_pkg::thrust_type starboard_thrust;
   ypdt_pkg::thrust_type port_thrust;
   ypdt_pkg::err_type    yaw_error;
   ypdt_pkg::thrust_type drive_value;

   modport source (output valid, output starboard_thrust, output port_thrust,
                   output yaw_error, output drive_value, input ready);
   modport sink   (input valid, input starboard_thrust, input port_thrust,
                   input yaw_error, input drive_value, output ready);
endinterface

FILE: design/ypdt_err_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ypdt_err_window
// Circular window of recent heading errors with an exact running sum.
// ----------------------------------------------------------------------------
module ypdt_err_window #(
   parameter int WINDOW_DEPTH = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ypdt_pkg::win_ctrl_type     win_ctrl,
   input  ypdt_pkg::err_type          commit_err,
   output logic [ypdt_pkg::ERR_W + $clog2(WINDOW_DEPTH)-1:0] window_total
);

   localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int SUM_W = ypdt_pkg::ERR_W + $clog2(WINDOW_DEPTH);

   ypdt_pkg::err_type       err_mem_ff [WINDOW_DEPTH];
   logic [WINDOW_DEPTH-1:0] valid_ff;
   logic [IDX_W-1:0]        slot_ff;
   logic [IDX_W-1:0]        slot_in;
   logic [SUM_W-1:0]        total_ff;
   logic [SUM_W-1:0]        total_in;
   ypdt_pkg::err_type       rd_data_ff;
   logic                    rd_valid_ff;
   ypdt_pkg::err_type       old_err;

   always_comb begin
      slot_in  = (slot_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
      // an entry never written counts as zero
      old_err  = rd_valid_ff ? rd_data_ff : '0;
      total_in = total_ff - SUM_W'(old_err) + SUM_W'(commit_err);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff  <= '0;
         valid_ff <= '0;
         total_ff <= '0;
      end else begin
         if (win_ctrl.advance) begin
            slot_ff <= slot_in;
         end
         if (win_ctrl.commit) begin
            valid_ff[slot_ff] <= 1'b1;
            total_ff          <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (win_ctrl.advance) begin
         rd_data_ff  <= err_mem_ff[slot_in];
         rd_valid_ff <= valid_ff[slot_in];
      end
      if (win_ctrl.commit) begin
         err_mem_ff[slot_ff] <= commit_err;
      end
   end

   assign window_total = total_ff;

`ifndef SYNTHESIS
   a_empty_sum_zero: assert property (@(posedge clock) disable iff (reset)
      valid_ff == '0 |-> total_ff == '0)
      else $error("window sum nonzero with no entries written");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= IDX_W'(WINDOW_DEPTH - 1))
      else $error("window slot out of range");

   a_commit_after_advance: assert property (@(posedge clock) disable iff (reset)
      win_ctrl.commit |-> $past(win_ctrl.advance))
      else $error("window commit without a preceding fetch");
`endif

endmodule

FILE: design/yaw_pid_differential_thrust.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yaw_pid_differential_thrust
// Yaw-hold PID controller with a windowed integral, driving a pair of
// differential surge thrusters.
// ----------------------------------------------------------------------------
// Usage
//   req_ch : one heading sample per transfer (measured, target, elapsed ms).
//   rsp_ch : one result per sample (starboard, port, heading error, drive).
//   csr_*  : gains and thrust limits, written while the block is idle.
// Timing
//   A new sample is taken once the previous one has left the arithmetic.
//   The products use a shift-and-add multiplier (one gain bit per cycle),
//   and the derivative term uses a restoring divider (one quotient bit
//   per cycle), which overlaps with the integral product.
// Reset
//   Clears the error window, previous error and gains; base and max thrust
//   return to 3000 and 7500.
// Stall
//   A finished result waits in the output register; the next sample is
//   still taken and runs up to the output stage, where it waits for the
//   receiver.
// ----------------------------------------------------------------------------
module yaw_pid_differential_thrust #(
   parameter int WINDOW_DEPTH = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   ypdt_req_if.sink               req_ch,
   ypdt_rsp_if.source             rsp_ch,
   input  logic                   csr_write_en,
   input  logic [2:0]             csr_index,
   input  ypdt_pkg::gain_type     csr_wdata
);

   localparam int SUM_W     = ypdt_pkg::ERR_W + $clog2(WINDOW_DEPTH);
   localparam int ACC_W     = SUM_W + ypdt_pkg::GAIN_W + 1;
   localparam int SUM_TW    = ACC_W + 1;
   localparam int NUM_W     = ypdt_pkg::GAIN_W + ypdt_pkg::ERR_W;
   localparam int MUL_STEPS = ypdt_pkg::GAIN_W;
   localparam int RUN_LAST  = MUL_STEPS + NUM_W - 1;
   localparam int CNT_W     = $clog2(RUN_LAST + 1);
   localparam int FRAC_W    = 8;
   localparam int SIDE_W    = ypdt_pkg::THR_W + 2;
   localparam int DT_W      = ypdt_pkg::MS_W;
   localparam int YAW_W     = ypdt_pkg::YAW_W;
   localparam int ERR_W     = ypdt_pkg::ERR_W;

   localparam ypdt_pkg::thrust_cfg_type BASE_RESET = 14'd3000;
   localparam ypdt_pkg::thrust_cfg_type MAX_RESET  = 14'd7500;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PREP = 3'd1;
   localparam logic [2:0] S_RUN  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_SAT  = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   localparam logic signed [SUM_TW-1:0] DRIVE_HI   = SUM_TW'(32767);
   localparam logic signed [SUM_TW-1:0] DRIVE_LO   = SUM_TW'(-32768);
   localparam logic signed [SIDE_W-1:0] SIDE_FLOOR = SIDE_W'(-32768);

   function automatic ypdt_pkg::thrust_type side_thrust(
      input logic                     sel,
      input ypdt_pkg::thrust_cfg_type base,
      input ypdt_pkg::thrust_cfg_type limit,
      input ypdt_pkg::thrust_type     drive
   );
      logic signed [SIDE_W-1:0] t;
      logic signed [SIDE_W-1:0] lim;
      t   = $signed({{(SIDE_W - ypdt_pkg::THR_CFG_W){1'b0}}, base});
      lim = $signed({{(SIDE_W - ypdt_pkg::THR_CFG_W){1'b0}}, limit});
      if (sel) begin
         t = t - $signed({{(SIDE_W - ypdt_pkg::THR_W){drive[ypdt_pkg::THR_W-1]}}, drive});
      end
      if (t > lim) begin
         t = lim;
      end
      if (t < SIDE_FLOOR) begin
         t = SIDE_FLOOR;
      end
      return t[ypdt_pkg::THR_W-1:0];
   endfunction

   // control
   logic [2:0]               state_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic                     rsp_valid_ff;
   ypdt_pkg::gain_type       prop_ff;
   ypdt_pkg::gain_type       integ_ff;
   ypdt_pkg::gain_type       deriv_ff;
   ypdt_pkg::thrust_cfg_type base_ff;
   ypdt_pkg::thrust_cfg_type max_ff;
   ypdt_pkg::err_type        last_ff;

   // sample and arithmetic
   ypdt_pkg::yaw_type        meas_ff;
   ypdt_pkg::yaw_type        targ_ff;
   ypdt_pkg::ms_type         dt_ff;
   ypdt_pkg::err_type        err_ff;
   logic                     neg_ff;
   logic                     star_ff;
   logic                     port_ff;
   ypdt_pkg::gain_type       gpi_ff;
   logic [ACC_W-1:0]         mpi_ff;
   logic [ACC_W-1:0]         acc_pi_ff;
   ypdt_pkg::gain_type       gd_ff;
   logic [NUM_W-1:0]         md_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [DT_W-1:0]          rem_ff;
   logic signed [SUM_TW-1:0] sum_ff;
   ypdt_pkg::thrust_type     drive_ff;

   // result register
   ypdt_pkg::thrust_type     rsp_star_ff;
   ypdt_pkg::thrust_type     rsp_port_ff;
   ypdt_pkg::err_type        rsp_err_ff;
   ypdt_pkg::thrust_type     rsp_drive_ff;

   logic                     req_fire;
   logic                     rsp_fire;
   logic                     rsp_free;
   ypdt_pkg::win_ctrl_type   win_ctrl;
   logic [SUM_W-1:0]         window_total;

   logic [YAW_W-1:0]         abs_meas;
   logic [YAW_W-1:0]         abs_targ;
   logic [YAW_W-1:0]         abs_diff;
   ypdt_pkg::err_type        err_now;
   logic [ERR_W:0]           err_delta;
   ypdt_pkg::err_type        delta_mag;
   logic                     closer;
   logic                     farther;
   logic                     meas_pos;
   logic [DT_W:0]            div_trial;
   logic                     div_ge;
   logic [SUM_TW-1:0]        pi_ext;
   logic [SUM_TW-1:0]        quo_ext;
   logic signed [SUM_TW-1:0] drive_shr;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;
   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready = (state_ff == S_IDLE);

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.starboard_thrust = rsp_star_ff;
   assign rsp_ch.port_thrust      = rsp_port_ff;
   assign rsp_ch.yaw_error        = rsp_err_ff;
   assign rsp_ch.drive_value      = rsp_drive_ff;

   assign win_ctrl.advance = req_fire;
   assign win_ctrl.commit  = (state_ff == S_PREP);

   ypdt_err_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .win_ctrl     (win_ctrl),
      .commit_err   (err_now),
      .window_total (window_total)
   );

   always_comb begin
      abs_meas = meas_ff[YAW_W-1] ? YAW_W'(-meas_ff) : YAW_W'(meas_ff);
      abs_targ = targ_ff[YAW_W-1] ? YAW_W'(-targ_ff) : YAW_W'(targ_ff);
      closer   = abs_targ < abs_meas;
      farther  = abs_targ > abs_meas;
      abs_diff = farther ? abs_targ - abs_meas : abs_meas - abs_targ;
      // only a heading of -32768 can push the error past the 15-bit range
      err_now  = abs_diff[YAW_W-1] ? {ERR_W{1'b1}} : abs_diff[ERR_W-1:0];
      meas_pos = !meas_ff[YAW_W-1] && (meas_ff != '0);

      err_delta = {1'b0, err_now} - {1'b0, last_ff};
      delta_mag = err_delta[ERR_W] ? ERR_W'(-err_delta) : err_delta[ERR_W-1:0];

      div_trial = {rem_ff, num_ff[NUM_W-1]};
      div_ge    = div_trial >= {1'b0, dt_ff};

      pi_ext    = SUM_TW'(acc_pi_ff);
      quo_ext   = SUM_TW'(num_ff);
      drive_shr = sum_ff >>> FRAC_W;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         prop_ff      <= '0;
         integ_ff     <= '0;
         deriv_ff     <= '0;
         base_ff      <= BASE_RESET;
         max_ff       <= MAX_RESET;
         last_ff      <= '0;
      end else begin
         // the output stage reloads the register on the same transfer
         if (rsp_fire && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write_en) begin
            unique case (csr_index)
               ypdt_pkg::CSR_PROP_GAIN:   prop_ff  <= csr_wdata;
               ypdt_pkg::CSR_INTEG_GAIN:  integ_ff <= csr_wdata;
               ypdt_pkg::CSR_DERIV_GAIN:  deriv_ff <= csr_wdata;
               ypdt_pkg::CSR_BASE_THRUST: base_ff  <= csr_wdata[ypdt_pkg::THR_CFG_W-1:0];
               ypdt_pkg::CSR_MAX_THRUST:  max_ff   <= csr_wdata[ypdt_pkg::THR_CFG_W-1:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               last_ff  <= err_now;
               cnt_ff   <= '0;
               state_ff <= S_RUN;
            end
            S_RUN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(RUN_LAST)) begin
                  state_ff <= S_SUM;
               end
            end
            S_SUM: state_ff <= S_SAT;
            S_SAT: state_ff <= S_OUT;
            S_OUT: begin
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               meas_ff <= req_ch.measured_yaw;
               targ_ff <= req_ch.target_yaw;
               dt_ff   <= (req_ch.elapsed_ms == '0) ? DT_W'(1) : req_ch.elapsed_ms;
            end
         end
         S_PREP: begin
            err_ff    <= err_now;
            neg_ff    <= err_delta[ERR_W];
            star_ff   <= (meas_pos && closer) || (meas_ff[YAW_W-1] && farther);
            port_ff   <= (meas_ff[YAW_W-1] && closer) || (meas_pos && farther);
            gpi_ff    <= prop_ff;
            mpi_ff    <= ACC_W'(err_now);
            acc_pi_ff <= '0;
            gd_ff     <= deriv_ff;
            md_ff     <= NUM_W'(delta_mag);
            num_ff    <= '0;
            rem_ff    <= '0;
         end
         S_RUN: begin
            // proportional then integral product, one gain bit per cycle
            if (cnt_ff < CNT_W'(2 * MUL_STEPS)) begin
               if (gpi_ff[0]) begin
                  acc_pi_ff <= acc_pi_ff + mpi_ff;
               end
               if (cnt_ff == CNT_W'(MUL_STEPS - 1)) begin
                  gpi_ff <= integ_ff;
                  mpi_ff <= ACC_W'(window_total);
               end else begin
                  gpi_ff <= gpi_ff >> 1;
                  mpi_ff <= mpi_ff << 1;
               end
            end
            // derivative numerator, then one quotient bit per cycle
            if (cnt_ff < CNT_W'(MUL_STEPS)) begin
               if (gd_ff[0]) begin
                  num_ff <= num_ff + md_ff;
               end
               gd_ff <= gd_ff >> 1;
               md_ff <= md_ff << 1;
            end else begin
               rem_ff <= div_ge ? DT_W'(div_trial - {1'b0, dt_ff}) : div_trial[DT_W-1:0];
               num_ff <= {num_ff[NUM_W-2:0], div_ge};
            end
         end
         S_SUM: begin
            sum_ff <= neg_ff ? $signed(pi_ext - quo_ext) : $signed(pi_ext + quo_ext);
         end
         S_SAT: begin
            if (drive_shr > DRIVE_HI) begin
               drive_ff <= DRIVE_HI[ypdt_pkg::THR_W-1:0];
            end else if (drive_shr < DRIVE_LO) begin
               drive_ff <= DRIVE_LO[ypdt_pkg::THR_W-1:0];
            end else begin
               drive_ff <= drive_shr[ypdt_pkg::THR_W-1:0];
            end
         end
         S_OUT: begin
            if (rsp_free) begin
               rsp_star_ff  <= side_thrust(star_ff, base_ff, max_ff, drive_ff);
               rsp_port_ff  <= side_thrust(port_ff, base_ff, max_ff, drive_ff);
               rsp_err_ff   <= err_ff;
               rsp_drive_ff <= drive_ff;
            end
         end
         default: ;
      endcase
   end

`ifndef SYNTHESIS
   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside the output stage");

   a_run_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RUN |-> cnt_ff <= CNT_W'(RUN_LAST))
      else $error("step counter past the last divide step");

   a_full_divide: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SUM |-> $past(cnt_ff) == CNT_W'(RUN_LAST))
      else $error("sum taken before the divider finished");
`endif

endmodule
